// ===== hdl/mfnp_pkg.sv =====
// Shared types and constants for the MIDI file note parser.
`default_nettype none
package mfnp_pkg;

  localparam int NoteDepth = 256;
  localparam int NoteAw    = 8;
  localparam int TickW     = 32;

  typedef enum logic [17:0] {
    PH_MAGIC  = 18'h00001,
    PH_HLEN   = 18'h00002,
    PH_FMT    = 18'h00004,
    PH_NTRK   = 18'h00008,
    PH_DIV    = 18'h00010,
    PH_TMAGIC = 18'h00020,
    PH_TLEN   = 18'h00040,
    PH_DELTA  = 18'h00080,
    PH_STATUS = 18'h00100,
    PH_KEY    = 18'h00200,
    PH_VEL    = 18'h00400,
    PH_SKIP   = 18'h00800,
    PH_MTYPE  = 18'h01000,
    PH_MLEN   = 18'h02000,
    PH_TEMPO  = 18'h04000,
    PH_XLEN   = 18'h08000,
    PH_TAIL   = 18'h10000,
    PH_DONE   = 18'h20000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NOTE     = 3'd0,
    KIND_TEMPO    = 3'd1,
    KIND_HDR_OK   = 3'd2,
    KIND_HDR_BAD  = 3'd3,
    KIND_FINISHED = 3'd4
  } kind_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  note_number;
    logic [31:0] on_tick;
    logic [31:0] release_tick;
    logic [31:0] tempo_tick;
    logic [23:0] quarter_usec;
    logic [14:0] division;
    logic [15:0] track_count;
    logic        last_of_run;
  } result_t;

  // Results produced by one byte, before the note table read is merged in.
  typedef struct packed {
    logic        r0_vld;
    logic        r0_is_note; // first result is a note; on_tick comes from the table
    result_t     r0;
    logic        r1_vld;
    result_t     r1;
  } step_t;

  localparam logic [7:0] HdrM0 = 8'h4D, HdrM1 = 8'h54, HdrM2 = 8'h68, HdrM3 = 8'h64;
  localparam logic [7:0] TrkM2 = 8'h72, TrkM3 = 8'h6B;
  localparam logic [14:0] TpbMask    = 15'h7FFF;
  localparam logic [14:0] TpbDefault = 15'd480;
  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [7:0] MetaEot   = 8'h2F;
  localparam logic [7:0] StMeta    = 8'hFF;
  localparam logic [7:0] StSysex   = 8'hF0;
  localparam logic [7:0] StEscape  = 8'hF7;
  localparam logic [3:0] TyNoteOff = 4'h8, TyNoteOn = 4'h9, TyPoly = 4'hA, TyCtrl = 4'hB;
  localparam logic [3:0] TyProg = 4'hC, TyPress = 4'hD, TyBend = 4'hE;

endpackage
`default_nettype wire

// ===== hdl/mfnp_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module mfnp_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== hdl/mfnp_core.sv =====
// Byte parser: phase machine, chunk accounting, note open flags.
`default_nettype none
module mfnp_core
  import mfnp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire logic [7:0]           file_byte,
  input  wire logic                 new_file,
  output step_t                     step,
  output logic                      tbl_wr_en,
  output logic [NoteAw-1:0]         tbl_addr,
  output logic [TickW-1:0]          tbl_wr_data
);
  phase_t       ph_r, ph_nxt;
  logic [2:0]   fbc_r, fbc_nxt;
  logic [15:0]  hw_r, hw_nxt;
  logic [15:0]  ttot_r, ttot_nxt;
  logic [15:0]  tseen_r, tseen_nxt;
  logic [31:0]  cleft_r, cleft_nxt;
  logic [31:0]  tick_r, tick_nxt;
  logic [7:0]   rs_r, rs_nxt;
  logic [31:0]  acc_r, acc_nxt;
  logic [7:0]   mk_r, mk_nxt;
  logic [31:0]  skip_r, skip_nxt;
  logic [23:0]  tmp_r, tmp_nxt;
  logic [7:0]   pn_r, pn_nxt;
  logic [NoteDepth-1:0] open_r, open_nxt;

  // values after an optional new_file clear
  phase_t       ph;
  logic [2:0]   fbc;
  logic [15:0]  hw, ttot, tseen;
  logic [31:0]  cleft, tick, acc, skip;
  logic [7:0]   rs, mk, pn;
  logic [23:0]  tmp;
  logic [NoteDepth-1:0] open_v;

  logic [7:0]  b;
  logic [31:0] vlq;
  logic [3:0]  ty, ty_st;
  logic [7:0]  rs_new;
  logic        in_chunk, end_trk, fin_a, fin_b;
  logic [15:0] tseen_inc;
  logic [7:0]  hdr_exp, trk_exp;
  logic [14:0] tpb;
  logic [15:0] hw_sh;
  logic [31:0] skl;
  logic        do_skl;
  logic [23:0] tmp_sh;

  always_comb begin
    b = file_byte;
    if (new_file) begin
      ph = PH_MAGIC; fbc = '0; hw = '0; ttot = '0; tseen = '0; cleft = '0;
      tick = '0; rs = '0; acc = '0; mk = '0; skip = '0; tmp = '0; pn = '0;
      open_v = '0;
    end else begin
      ph = ph_r; fbc = fbc_r; hw = hw_r; ttot = ttot_r; tseen = tseen_r;
      cleft = cleft_r; tick = tick_r; rs = rs_r; acc = acc_r; mk = mk_r;
      skip = skip_r; tmp = tmp_r; pn = pn_r; open_v = open_r;
    end
  end

  always_comb begin
    unique case (fbc[1:0])
      2'd0: hdr_exp = HdrM0;
      2'd1: hdr_exp = HdrM1;
      2'd2: hdr_exp = HdrM2;
      default: hdr_exp = HdrM3;
    endcase
    unique case (fbc[1:0])
      2'd0: trk_exp = HdrM0;
      2'd1: trk_exp = HdrM1;
      2'd2: trk_exp = TrkM2;
      default: trk_exp = TrkM3;
    endcase
  end

  always_comb begin
    ph_nxt = ph; fbc_nxt = fbc; hw_nxt = hw; ttot_nxt = ttot; tseen_nxt = tseen;
    cleft_nxt = cleft; tick_nxt = tick; rs_nxt = rs; acc_nxt = acc; mk_nxt = mk;
    skip_nxt = skip; tmp_nxt = tmp; pn_nxt = pn; open_nxt = open_v;
    step = '0;
    tbl_wr_en = 1'b0;
    tbl_addr = pn;
    tbl_wr_data = tick;
    fin_a = 1'b0;
    vlq = {acc[24:0], b[6:0]};
    hw_sh = {hw[7:0], b};
    tpb = hw_sh[14:0] & TpbMask;
    if (tpb == '0) tpb = TpbDefault;
    rs_new = b[7] ? b : rs;
    ty_st = rs_new[7:4];
    ty = rs[7:4];
    skl = '0;
    do_skl = 1'b0;
    tmp_sh = {tmp[15:0], b};
    in_chunk = (ph == PH_DELTA) || (ph == PH_STATUS) || (ph == PH_KEY) ||
               (ph == PH_VEL) || (ph == PH_SKIP) || (ph == PH_MTYPE) ||
               (ph == PH_MLEN) || (ph == PH_TEMPO) || (ph == PH_XLEN) ||
               (ph == PH_TAIL);
    tseen_inc = tseen + 16'd1;

    unique case (ph)
      PH_MAGIC: begin
        if (b != hdr_exp) begin
          ph_nxt = PH_DONE;
          step.r0_vld = 1'b1;
          step.r0.kind = KIND_HDR_BAD;
        end else if (fbc == 3'd3) begin
          fbc_nxt = '0; ph_nxt = PH_HLEN;
        end else begin
          fbc_nxt = fbc + 3'd1;
        end
      end
      PH_HLEN, PH_FMT, PH_NTRK, PH_DIV: begin
        hw_nxt = hw_sh;
        fbc_nxt = fbc + 3'd1;
        if (ph == PH_HLEN) begin
          if (fbc == 3'd3) begin fbc_nxt = '0; ph_nxt = PH_FMT; end
        end else if (fbc == 3'd1) begin
          fbc_nxt = '0;
          if (ph == PH_FMT) begin
            ph_nxt = PH_NTRK;
          end else if (ph == PH_NTRK) begin
            ttot_nxt = hw_sh; ph_nxt = PH_DIV;
          end else begin
            step.r0_vld = 1'b1;
            step.r0.kind = KIND_HDR_OK;
            step.r0.division = tpb;
            step.r0.track_count = ttot;
            tseen_nxt = '0;
            if (ttot == '0) begin
              fin_a = 1'b1;
            end else begin
              ph_nxt = PH_TMAGIC;
            end
          end
        end
      end
      PH_TMAGIC: begin
        if (b != trk_exp) begin
          fin_a = 1'b1;
        end else if (fbc == 3'd3) begin
          fbc_nxt = '0; acc_nxt = '0; ph_nxt = PH_TLEN;
        end else begin
          fbc_nxt = fbc + 3'd1;
        end
      end
      PH_TLEN: begin
        acc_nxt = {acc[23:0], b};
        fbc_nxt = fbc + 3'd1;
        if (fbc == 3'd3) begin
          fbc_nxt = '0; acc_nxt = '0; tick_nxt = '0; rs_nxt = '0;
          cleft_nxt = {acc[23:0], b};
          if ({acc[23:0], b} == '0) begin
            // empty chunk: end the track now
            cleft_nxt = '0;
            tseen_nxt = tseen_inc;
            if (tseen_inc >= ttot) fin_a = 1'b1;
            else begin ph_nxt = PH_TMAGIC; end
          end else begin
            ph_nxt = PH_DELTA;
          end
        end
      end
      PH_DELTA: begin
        acc_nxt = vlq;
        if (!b[7]) begin
          tick_nxt = tick + vlq; acc_nxt = '0; ph_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == StMeta) begin
          ph_nxt = PH_MTYPE;
        end else if (b == StSysex || b == StEscape) begin
          acc_nxt = '0; ph_nxt = PH_XLEN;
        end else begin
          rs_nxt = rs_new;
          if (ty_st == TyNoteOff || ty_st == TyNoteOn) begin
            if (b[7]) ph_nxt = PH_KEY;
            else begin pn_nxt = b; ph_nxt = PH_VEL; end
          end else if (ty_st == TyPoly || ty_st == TyCtrl || ty_st == TyBend) begin
            do_skl = 1'b1; skl = b[7] ? 32'd2 : 32'd1;
          end else if (ty_st == TyProg || ty_st == TyPress) begin
            do_skl = 1'b1; skl = b[7] ? 32'd1 : 32'd0;
          end else begin
            ph_nxt = PH_DELTA;
          end
        end
      end
      PH_KEY: begin
        pn_nxt = b; ph_nxt = PH_VEL;
      end
      PH_VEL: begin
        if (ty == TyNoteOn && b != '0) begin
          tbl_wr_en = 1'b1;
          open_nxt[pn] = 1'b1;
        end else if (open_v[pn]) begin
          step.r0_vld = 1'b1;
          step.r0_is_note = 1'b1;
          step.r0.kind = KIND_NOTE;
          step.r0.note_number = pn;
          step.r0.release_tick = tick;
          open_nxt[pn] = 1'b0;
        end
        ph_nxt = PH_DELTA;
      end
      PH_SKIP: begin
        if (skip <= 32'd1) begin skip_nxt = '0; ph_nxt = PH_DELTA; end
        else skip_nxt = skip - 32'd1;
      end
      PH_MTYPE: begin
        mk_nxt = b; acc_nxt = '0; ph_nxt = PH_MLEN;
      end
      PH_MLEN: begin
        acc_nxt = vlq;
        if (!b[7]) begin
          acc_nxt = '0;
          if (mk == MetaTempo && vlq == 32'd3) begin
            tmp_nxt = '0; fbc_nxt = '0; ph_nxt = PH_TEMPO;
          end else if (mk == MetaEot) begin
            ph_nxt = PH_TAIL;
          end else begin
            do_skl = 1'b1; skl = vlq;
          end
        end
      end
      PH_TEMPO: begin
        tmp_nxt = tmp_sh;
        fbc_nxt = fbc + 3'd1;
        if (fbc == 3'd2) begin
          fbc_nxt = '0;
          step.r0_vld = 1'b1;
          step.r0.kind = KIND_TEMPO;
          step.r0.tempo_tick = tick;
          step.r0.quarter_usec = tmp_sh;
          ph_nxt = PH_DELTA;
        end
      end
      PH_XLEN: begin
        acc_nxt = vlq;
        if (!b[7]) begin
          acc_nxt = '0; do_skl = 1'b1; skl = vlq;
        end
      end
      PH_TAIL: ;
      PH_DONE: ;
      default: ph_nxt = PH_DONE;
    endcase

    if (do_skl) begin
      if (skl == '0) ph_nxt = PH_DELTA;
      else begin skip_nxt = skl; ph_nxt = PH_SKIP; end
    end
    if (fin_a) ph_nxt = PH_DONE;

    // chunk byte accounting
    end_trk = in_chunk && (cleft <= 32'd1);
    fin_b = 1'b0;
    if (in_chunk) begin
      if (end_trk) begin
        cleft_nxt = '0;
        tseen_nxt = tseen_inc;
        if (tseen_inc >= ttot) begin
          fin_b = 1'b1; ph_nxt = PH_DONE;
        end else begin
          ph_nxt = PH_TMAGIC; fbc_nxt = '0;
        end
      end else begin
        cleft_nxt = cleft - 32'd1;
      end
    end

    // place finish result after any earlier one
    if (fin_a || fin_b) begin
      if (step.r0_vld) begin
        step.r1_vld = 1'b1;
        step.r1.kind = KIND_FINISHED;
        step.r1.last_of_run = 1'b1;
      end else begin
        step.r0_vld = 1'b1;
        step.r0.kind = KIND_FINISHED;
      end
    end
    if (step.r0_vld && !step.r1_vld) step.r0.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_MAGIC; fbc_r <= '0; hw_r <= '0; ttot_r <= '0; tseen_r <= '0;
      cleft_r <= '0; tick_r <= '0; rs_r <= '0; acc_r <= '0; mk_r <= '0;
      skip_r <= '0; tmp_r <= '0; pn_r <= '0; open_r <= '0;
    end else if (step_en) begin
      ph_r <= ph_nxt; fbc_r <= fbc_nxt; hw_r <= hw_nxt; ttot_r <= ttot_nxt;
      tseen_r <= tseen_nxt; cleft_r <= cleft_nxt; tick_r <= tick_nxt;
      rs_r <= rs_nxt; acc_r <= acc_nxt; mk_r <= mk_nxt; skip_r <= skip_nxt;
      tmp_r <= tmp_nxt; pn_r <= pn_nxt; open_r <= open_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/mfnp_outq.sv =====
// Four-entry result queue that merges the note start tick into note results.
`default_nettype none
module mfnp_outq
  import mfnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  step_t            step_in,
  input  wire logic [31:0] tbl_rd_data,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          out_res
);
  // stage: step registered, table read data arrives in the same cycle
  logic    stg_vld_r, stg_vld_nxt;
  step_t   stg_r;
  result_t q_r [4];
  logic [1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_in;
  logic    pop;
  result_t r0;

  assign pop = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_res = q_r[rp_r];
  // leave space for whatever the staged byte and the next byte may add
  assign room = (cnt_r + {1'b0, n_in}) <= 3'd2;

  always_comb begin
    r0 = stg_r.r0;
    if (stg_r.r0_is_note) r0.on_tick = tbl_rd_data;
    n_in = '0;
    if (stg_vld_r) n_in = {1'b0, stg_r.r0_vld} + {1'b0, stg_r.r1_vld};
    stg_vld_nxt = push;
    rp_nxt = rp_r + {1'b0, pop};
    wp_nxt = wp_r + n_in;
    cnt_nxt = cnt_r + {1'b0, n_in} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0; rp_r <= '0; wp_r <= '0; cnt_r <= '0;
    end else begin
      stg_vld_r <= stg_vld_nxt; rp_r <= rp_nxt; wp_r <= wp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) stg_r <= step_in;
    if (stg_vld_r && stg_r.r0_vld) q_r[wp_r] <= r0;
    if (stg_vld_r && stg_r.r1_vld) q_r[wp_r + 2'd1] <= stg_r.r1;
  end
endmodule
`default_nettype wire

// ===== hdl/midi_file_note_parser.sv =====
// Top level of the MIDI file note parser.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall  file_byte, new_file
//  out_      output     out_valid/out_stall  kind .. last_of_run
//
// One file byte per cycle while in_stall is low; each byte passes the parser in its
// accept cycle, then one stage where the note table read returns, then a four-entry
// result queue. A byte gives up to two results, at one a cycle when out_stall is low.
// Reset is synchronous: phase to header magic, note open flags clear.
// in_stall rises only when queued plus staged results leave under two free entries.
`default_nettype none
module midi_file_note_parser
  import mfnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_file_byte,
  input  wire logic        in_new_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_note_number,
  output logic [31:0]      out_on_tick,
  output logic [31:0]      out_release_tick,
  output logic [31:0]      out_tempo_tick,
  output logic [23:0]      out_quarter_usec,
  output logic [14:0]      out_division,
  output logic [15:0]      out_track_count,
  output logic             out_last_of_run
);
  step_t                 step;
  logic                  room, acc_en, tbl_wr_en;
  logic [NoteAw-1:0]     tbl_addr;
  logic [TickW-1:0]      tbl_wr_data, tbl_rd_data;
  result_t               res;

  assign in_stall = !room;
  assign acc_en = in_valid && room;

  mfnp_core u_core (
    .clk, .rst_n, .step_en(acc_en), .file_byte(in_file_byte), .new_file(in_new_file),
    .step, .tbl_wr_en, .tbl_addr, .tbl_wr_data
  );

  mfnp_ram #(.Width(TickW), .Depth(NoteDepth)) u_ram (
    .clk, .wr_en(acc_en && tbl_wr_en), .wr_addr(tbl_addr), .wr_data(tbl_wr_data),
    .rd_en(acc_en), .rd_addr(tbl_addr), .rd_data(tbl_rd_data)
  );

  mfnp_outq u_outq (
    .clk, .rst_n, .push(acc_en), .step_in(step), .tbl_rd_data,
    .room, .out_valid, .out_stall, .out_res(res)
  );

  assign out_kind           = res.kind;
  assign out_note_number    = res.note_number;
  assign out_on_tick        = res.on_tick;
  assign out_release_tick   = res.release_tick;
  assign out_tempo_tick     = res.tempo_tick;
  assign out_quarter_usec   = res.quarter_usec;
  assign out_division       = res.division;
  assign out_track_count    = res.track_count;
  assign out_last_of_run    = res.last_of_run;
endmodule
`default_nettype wire

// ===== tb/tb_midi_file_note_parser.sv =====
// Testbench for the MIDI file note parser: directed bytes, then random files.
`timescale 1ns / 1ps
module tb_midi_file_note_parser
  import mfnp_pkg::*;
();

  localparam int RandItems = 1750;
  localparam int IdleLimit = 4000;

  typedef enum int { CHK_PRED, CHK_REJECT, CHK_HDR480 } chk_t;
  typedef struct {
    logic [7:0] b;
    logic       nf;
    chk_t       chk;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_file_byte = 8'h00;
  logic        in_new_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_note_number;
  logic [31:0] out_on_tick;
  logic [31:0] out_release_tick;
  logic [31:0] out_tempo_tick;
  logic [23:0] out_quarter_usec;
  logic [14:0] out_division;
  logic [15:0] out_track_count;
  logic        out_last_of_run;

  midi_file_note_parser dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int rand_sent = 0;
  int quiet = 0;

  result_t note_results[$];   // expected results, oldest first
  result_t byte_results[$];   // results of the byte being parsed
  logic [7:0] file_q[$];

  // parser state mirror
  phase_t      ph;
  int          fbc;
  logic [15:0] hword, ttot, tseen;
  logic [31:0] cleft, tick, lacc, sleft;
  logic [7:0]  rstat, mkind, pnote;
  logic [23:0] tempo_acc;
  logic [31:0] start_tick [256];
  logic        note_is_open [256];
  logic [7:0]  hdr_magic [4] = '{HdrM0, HdrM1, HdrM2, HdrM3};
  logic [7:0]  trk_magic [4] = '{HdrM0, HdrM1, TrkM2, TrkM3};

  row_t directed [] = '{
    '{8'h5A, 1'b1, CHK_REJECT},
    '{8'h4D, 1'b1, CHK_PRED}, '{8'h54, 1'b0, CHK_PRED}, '{8'h68, 1'b0, CHK_PRED},
    '{8'h64, 1'b0, CHK_PRED},
    '{8'h00, 1'b0, CHK_PRED}, '{8'h00, 1'b0, CHK_PRED}, '{8'h00, 1'b0, CHK_PRED},
    '{8'h06, 1'b0, CHK_PRED},
    '{8'h00, 1'b0, CHK_PRED}, '{8'h00, 1'b0, CHK_PRED},
    '{8'h00, 1'b0, CHK_PRED}, '{8'h01, 1'b0, CHK_PRED},
    '{8'h00, 1'b0, CHK_PRED}, '{8'h00, 1'b0, CHK_HDR480},
    '{8'h4D, 1'b0, CHK_PRED}, '{8'h54, 1'b0, CHK_PRED}, '{8'h72, 1'b0, CHK_PRED},
    '{8'h6B, 1'b0, CHK_PRED},
    '{8'h00, 1'b0, CHK_PRED}, '{8'h00, 1'b0, CHK_PRED}, '{8'h00, 1'b0, CHK_PRED},
    '{8'h0F, 1'b0, CHK_PRED},
    // note on, then note off by running status with velocity zero
    '{8'h00, 1'b0, CHK_PRED}, '{8'h90, 1'b0, CHK_PRED}, '{8'h3C, 1'b0, CHK_PRED},
    '{8'h40, 1'b0, CHK_PRED},
    '{8'h81, 1'b0, CHK_PRED}, '{8'h00, 1'b0, CHK_PRED}, '{8'h3C, 1'b0, CHK_PRED},
    '{8'h00, 1'b0, CHK_PRED},
    // tempo whose last byte also ends the chunk and the file
    '{8'h00, 1'b0, CHK_PRED}, '{8'hFF, 1'b0, CHK_PRED}, '{8'h51, 1'b0, CHK_PRED},
    '{8'h03, 1'b0, CHK_PRED}, '{8'h07, 1'b0, CHK_PRED}, '{8'hA1, 1'b0, CHK_PRED},
    '{8'h20, 1'b0, CHK_PRED},
    '{8'h4D, 1'b0, CHK_PRED}
  };

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    errors++;
  endtask

  task automatic emit(kind_t k, logic [7:0] nn, logic [31:0] on_t, logic [31:0] rel_t,
                      logic [31:0] tt, logic [23:0] us, logic [14:0] tpb, logic [15:0] tc);
    result_t r;
    r.kind = k;
    r.note_number = nn;
    r.on_tick = on_t;
    r.release_tick = rel_t;
    r.tempo_tick = tt;
    r.quarter_usec = us;
    r.division = tpb;
    r.track_count = tc;
    r.last_of_run = 1'b0;
    byte_results = {byte_results, r};
  endtask

  task automatic clear_parser();
    ph = PH_MAGIC;
    fbc = 0;
    {hword, ttot, tseen} = '0;
    {cleft, tick, lacc, sleft} = '0;
    {rstat, mkind, pnote} = '0;
    tempo_acc = '0;
    foreach (note_is_open[i]) note_is_open[i] = 1'b0;
  endtask

  task automatic finish_file();
    ph = PH_DONE;
    emit(KIND_FINISHED, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic close_track();
    cleft = 0;
    tseen = tseen + 16'd1;
    if (tseen >= ttot) begin
      finish_file();
    end else begin
      ph = PH_TMAGIC;
      fbc = 0;
    end
  endtask

  function automatic bit vlq_done(logic [7:0] b);
    lacc = {lacc[24:0], b[6:0]};
    return !b[7];
  endfunction

  task automatic skip_or_delta(logic [31:0] len);
    if (len == 0) begin
      ph = PH_DELTA;
    end else begin
      sleft = len;
      ph = PH_SKIP;
    end
  endtask

  task automatic parse_byte(logic [7:0] b, logic nf);
    bit          in_chk;
    logic [3:0]  ty;
    logic [31:0] len;
    logic [14:0] tpb;
    byte_results.delete();
    if (nf) clear_parser();
    in_chk = ph inside {PH_DELTA, PH_STATUS, PH_KEY, PH_VEL, PH_SKIP, PH_MTYPE,
                        PH_MLEN, PH_TEMPO, PH_XLEN, PH_TAIL};
    unique case (ph)
      PH_MAGIC: begin
        if (b != hdr_magic[fbc & 3]) begin
          ph = PH_DONE;
          emit(KIND_HDR_BAD, 0, 0, 0, 0, 0, 0, 0);
        end else if (++fbc >= 4) begin
          fbc = 0;
          ph = PH_HLEN;
        end
      end
      PH_HLEN, PH_FMT, PH_NTRK, PH_DIV: begin
        hword = {hword[7:0], b};
        fbc++;
        if (ph == PH_HLEN) begin
          if (fbc >= 4) begin
            fbc = 0;
            ph = PH_FMT;
          end
        end else if (fbc >= 2) begin
          fbc = 0;
          if (ph == PH_FMT) begin
            ph = PH_NTRK;
          end else if (ph == PH_NTRK) begin
            ttot = hword;
            ph = PH_DIV;
          end else begin
            tpb = hword[14:0] & TpbMask;
            if (tpb == 0) tpb = TpbDefault;
            emit(KIND_HDR_OK, 0, 0, 0, 0, 0, tpb, ttot);
            tseen = 0;
            if (ttot == 0) finish_file();
            else ph = PH_TMAGIC;
          end
        end
      end
      PH_TMAGIC: begin
        if (b != trk_magic[fbc & 3]) begin
          finish_file();
        end else if (++fbc >= 4) begin
          fbc = 0;
          lacc = 0;
          ph = PH_TLEN;
        end
      end
      PH_TLEN: begin
        lacc = {lacc[23:0], b};
        if (++fbc >= 4) begin
          fbc = 0;
          cleft = lacc;
          lacc = 0;
          tick = 0;
          rstat = 0;
          if (cleft == 0) close_track();
          else ph = PH_DELTA;
        end
      end
      PH_DELTA: begin
        if (vlq_done(b)) begin
          tick = tick + lacc;
          lacc = 0;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == StMeta) begin
          ph = PH_MTYPE;
        end else if (b == StSysex || b == StEscape) begin
          lacc = 0;
          ph = PH_XLEN;
        end else begin
          if (b[7]) rstat = b;
          ty = rstat[7:4];
          if (ty == TyNoteOff || ty == TyNoteOn) begin
            if (b[7]) begin
              ph = PH_KEY;
            end else begin
              pnote = b;
              ph = PH_VEL;
            end
          end else if (ty == TyPoly || ty == TyCtrl || ty == TyBend) begin
            skip_or_delta(b[7] ? 2 : 1);
          end else if (ty == TyProg || ty == TyPress) begin
            skip_or_delta(b[7] ? 1 : 0);
          end else begin
            ph = PH_DELTA;
          end
        end
      end
      PH_KEY: begin
        pnote = b;
        ph = PH_VEL;
      end
      PH_VEL: begin
        if (rstat[7:4] == TyNoteOn && b != 0) begin
          start_tick[pnote] = tick;
          note_is_open[pnote] = 1'b1;
        end else if (note_is_open[pnote]) begin
          emit(KIND_NOTE, pnote, start_tick[pnote], tick, 0, 0, 0, 0);
          note_is_open[pnote] = 1'b0;
        end
        ph = PH_DELTA;
      end
      PH_SKIP: begin
        if (sleft <= 1) begin
          sleft = 0;
          ph = PH_DELTA;
        end else begin
          sleft--;
        end
      end
      PH_MTYPE: begin
        mkind = b;
        lacc = 0;
        ph = PH_MLEN;
      end
      PH_MLEN: begin
        if (vlq_done(b)) begin
          len = lacc;
          lacc = 0;
          if (mkind == MetaTempo && len == 3) begin
            tempo_acc = 0;
            fbc = 0;
            ph = PH_TEMPO;
          end else if (mkind == MetaEot) begin
            ph = PH_TAIL;
          end else begin
            skip_or_delta(len);
          end
        end
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        if (++fbc >= 3) begin
          fbc = 0;
          emit(KIND_TEMPO, 0, 0, 0, tick, tempo_acc, 0, 0);
          ph = PH_DELTA;
        end
      end
      PH_XLEN: begin
        if (vlq_done(b)) begin
          len = lacc;
          lacc = 0;
          skip_or_delta(len);
        end
      end
      PH_TAIL: ;
      default: ph = PH_DONE;
    endcase
    if (in_chk) begin
      if (cleft <= 1) close_track();
      else cleft--;
    end
    if (byte_results.size() > 0) byte_results[$].last_of_run = 1'b1;
  endtask

  task automatic send_byte(logic [7:0] b, logic nf, chk_t chk);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_file_byte <= b;
    in_new_file <= nf;
    // the transaction is taken at the first edge with in_stall low
    @(posedge clk iff !in_stall);
    parse_byte(b, nf);
    if (chk == CHK_PRED) begin
      note_results = {note_results, byte_results};
    end else begin
      r = '0;
      r.last_of_run = 1'b1;
      if (chk == CHK_REJECT) begin
        r.kind = KIND_HDR_BAD;
      end else begin
        r.kind = KIND_HDR_OK;
        r.division = 15'd480;
        r.track_count = 16'd1;
      end
      note_results = {note_results, r};
    end
  endtask

  // random file generation
  task automatic put(ref logic [7:0] q[$], input logic [31:0] v);
    q = {q, v[7:0]};
  endtask

  task automatic put_vlq(ref logic [7:0] q[$], input logic [31:0] v);
    logic [7:0] grp [$];
    grp.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    q = {q, grp};
  endtask

  task automatic put_delta(ref logic [7:0] q[$]);
    int r;
    r = $urandom_range(99);
    if (r < 70) put_vlq(q, $urandom_range(0, 127));
    else if (r < 95) put_vlq(q, $urandom_range(0, 16383));
    else put_vlq(q, $urandom);
  endtask

  task automatic build_track(ref logic [7:0] ck[$]);
    int          nev, sel, n;
    logic [7:0]  st, note, rs;
    bit          on;
    rs = 8'h00;
    nev = $urandom_range(1, 12);
    repeat (nev) begin
      put_delta(ck);
      sel = $urandom_range(0, 19);
      unique case (sel)
        8: begin
          put(ck, StMeta); put(ck, MetaTempo); put(ck, 3);
          repeat (3) put(ck, $urandom);
        end
        9: begin
          put(ck, StMeta);
          put(ck, $urandom_range(0, 1) ? $urandom : MetaTempo);
          n = $urandom_range(0, 4);
          put_vlq(ck, n);
          repeat (n) put(ck, $urandom);
        end
        10: begin
          put(ck, $urandom_range(0, 1) ? StSysex : StEscape);
          n = $urandom_range(0, 4);
          put_vlq(ck, n);
          repeat (n) put(ck, $urandom);
        end
        11, 12: begin
          if (sel == 11) st = {($urandom_range(0, 2) == 0) ? TyPoly :
                               ($urandom_range(0, 1) ? TyCtrl : TyBend), 4'($urandom)};
          else st = {$urandom_range(0, 1) ? TyProg : TyPress, 4'($urandom)};
          if (st != rs || $urandom_range(0, 1)) put(ck, st);
          rs = st;
          repeat ((sel == 11) ? 2 : 1) put(ck, $urandom_range(0, 127));
        end
        13: put(ck, $urandom);
        14: begin
          put(ck, StMeta); put(ck, MetaEot); put(ck, 0);
        end
        default: begin
          note = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(60, 67));
          on = $urandom_range(0, 1);
          st = {(on || $urandom_range(0, 1)) ? TyNoteOn : TyNoteOff, 4'($urandom)};
          if (st != rs || note[7] || $urandom_range(0, 1)) put(ck, st);
          rs = st;
          put(ck, note);
          if (st[7:4] == TyNoteOn) put(ck, on ? $urandom_range(1, 127) : 0);
          else put(ck, $urandom_range(0, 127));
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      put(ck, 0); put(ck, StMeta); put(ck, MetaEot); put(ck, 0);
    end
  endtask

  task automatic build_file();
    logic [7:0]  ck [$];
    logic [15:0] ntrk, dv;
    logic [31:0] len;
    int          r;
    file_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 8)) put(file_q, $urandom);
    end else begin
      foreach (hdr_magic[i]) put(file_q, hdr_magic[i]);
      if ($urandom_range(0, 19) == 0) file_q[$urandom_range(0, 3)] = $urandom;
      put(file_q, 0); put(file_q, 0); put(file_q, 0); put(file_q, 6);
      repeat (2) put(file_q, $urandom);
      r = $urandom_range(0, 19);
      ntrk = (r == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      put(file_q, ntrk[15:8]); put(file_q, ntrk[7:0]);
      r = $urandom_range(0, 5);
      dv = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'h7FFF : 16'($urandom);
      put(file_q, dv[15:8]); put(file_q, dv[7:0]);
      repeat (ntrk) begin
        ck.delete();
        build_track(ck);
        foreach (trk_magic[i]) put(file_q, trk_magic[i]);
        if ($urandom_range(0, 29) == 0) file_q[$ - $urandom_range(0, 3)] = $urandom;
        len = ck.size();
        // cut short or run long now and then
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, ck.size() + 4);
        put(file_q, len[31:24]); put(file_q, len[23:16]);
        put(file_q, len[15:8]); put(file_q, len[7:0]);
        file_q = {file_q, ck};
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) put(file_q, $urandom);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (note_results.size() == 0) begin
        report("unexpected kind", out_kind, 0);
      end else begin
        w = note_results.pop_front();
        if (out_kind !== w.kind) report("kind", out_kind, w.kind);
        if (out_note_number !== w.note_number)
          report("note_number", out_note_number, w.note_number);
        if (out_on_tick !== w.on_tick) report("on_tick", out_on_tick, w.on_tick);
        if (out_release_tick !== w.release_tick)
          report("release_tick", out_release_tick, w.release_tick);
        if (out_tempo_tick !== w.tempo_tick)
          report("tempo_tick", out_tempo_tick, w.tempo_tick);
        if (out_quarter_usec !== w.quarter_usec)
          report("quarter_usec", out_quarter_usec, w.quarter_usec);
        if (out_division !== w.division)
          report("division", out_division, w.division);
        if (out_track_count !== w.track_count)
          report("track_count", out_track_count, w.track_count);
        if (out_last_of_run !== w.last_of_run)
          report("last_of_run", out_last_of_run, w.last_of_run);
      end
    end
  end

  // watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IdleLimit) begin
        $display("[midi_file_note_parser] ERROR");
        $finish;
      end
    end
  end

  int idle_set [4] = '{0, 58, 0, 11};
  int stall_set [4] = '{0, 0, 58, 11};

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_byte(directed[i].b, directed[i].nf, directed[i].chk);
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      while (rand_sent < (p + 1) * RandItems / 4) begin
        build_file();
        foreach (file_q[i]) send_byte(file_q[i], i == 0, CHK_PRED);
        rand_sent += file_q.size();
      end
      // hold the sender until every result has drained
      in_valid <= 1'b0;
      @(posedge clk);
      while (note_results.size() != 0) @(posedge clk);
    end
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (errors == 0 && note_results.size() == 0) begin
      $display("[midi_file_note_parser] OK");
    end else begin
      $display("[midi_file_note_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mfnp_pkg.sv
hdl/mfnp_ram.sv
hdl/mfnp_core.sv
hdl/mfnp_outq.sv
hdl/midi_file_note_parser.sv
tb/tb_midi_file_note_parser.sv
